// ===== src/asma_pkg.sv =====
// Shared types and constants of the ADC scan moving-average block.
`timescale 1ns / 1ps
`default_nettype none

package asma_pkg;

	localparam int NUM_CHANNELS = 4;
	localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CHAN_W = 4;
	localparam int RES_W  = 10;
	localparam int SMP_W  = 11;
	localparam int HIST_N = 3;
	localparam int SLOT_W = 2;
	localparam int FRAME_W = 16;
	localparam logic [SLOT_W-1:0] SLOT_RESET = SLOT_W'(2);

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_START = 2'd1,
		PH_CONV  = 2'd2,
		PH_DONE  = 2'd3
	} phase_t;

	typedef struct packed {
		logic              mode;
		logic              conv_busy;
		logic [RES_W-1:0]  adc_result;
		logic [CHAN_W-1:0] read_channel;
	} req_t;

	typedef struct packed {
		logic               start_conv;
		logic [CHAN_W-1:0]  conv_channel;
		logic               avg_written;
		logic [SMP_W-1:0]   read_value;
		logic [FRAME_W-1:0] frame_count;
	} rsp_t;

	// One memory row per channel: the stored average and the three history samples.
	typedef struct packed {
		logic [SMP_W-1:0]             avg;
		logic [HIST_N-1:0][SMP_W-1:0] hist;
	} row_t;

endpackage

`default_nettype wire

// ===== src/asma_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module asma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/adc_scan_moving_average.sv =====
// Top level of the round-robin ADC scan sequencer with per-channel moving average.
`timescale 1ns / 1ps
`default_nettype none

// Usage: each beat on the req channel is either a timer tick (mode 0) or a read of a
// channel's stored average (mode 1). Ticks drive the start, convert and done phases:
// a start tick advances the scan channel and pulses start_conv, convert ticks wait on
// conv_busy, and the done tick stores the four-sample average of the doubled result.
// Every accepted beat produces exactly one beat on the rsp channel.
// A req beat passes two register stages: rsp_valid rises when it moves from the lookup
// stage into the output register. One beat is taken per cycle while req_stall is low;
// the averages and history live in one row-per-channel RAM whose registered read port
// is read in the accept cycle and written back when the beat leaves the lookup stage,
// with a forwarding path when a read hits the row being written on the same edge.
// Reset clears the phase, scan channel, frame counter and row valid bits and sets the
// history slot to SLOT_RESET; unwritten rows read as zero, so no clearing pass is needed.
// When rsp_stall is held, one result waits in the output register and one in the
// lookup stage; req_stall rises only once both are full.
module adc_scan_moving_average import asma_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	// Control state.
	phase_t              phase_q, phase_d;
	logic [CHAN_W-1:0]   scan_q, scan_d;
	logic [SLOT_W-1:0]   slot_q, slot_d;
	logic [FRAME_W-1:0]  frame_q, frame_d;
	logic [NUM_CHANNELS-1:0] row_vld_q;

	logic accept, tick_start, tick_done;

	// Lookup stage.
	logic              valid_s1, read_s1, inrange_s1, done_s1, start_s1, fwd_s1;
	logic [CH_W-1:0]   addr_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [SMP_W-1:0]  sample_s1;
	logic [CHAN_W-1:0] chan_s1;
	logic [FRAME_W-1:0] frame_s1;
	row_t              fwd_row_s1;
	logic              s1_move;

	// Output register.
	logic rsp_valid_q;
	rsp_t rsp_q;

	// Memory ports.
	logic [CH_W-1:0]   raddr, waddr;
	logic              we;
	row_t              wrow, rdata, row;
	logic [SMP_W+1:0]  sum;
	logic              fwd_d;

	assign s1_move   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !s1_move;
	assign accept    = req_valid && !req_stall;

	// Phase machine: next state.
	always_comb begin
		phase_d = phase_q;
		if (accept && !req.mode) begin
			case (phase_q)
				PH_IDLE, PH_START: phase_d = PH_CONV;
				PH_CONV: begin
					if (!req.conv_busy) begin
						phase_d = PH_DONE;
					end
				end
				PH_DONE: phase_d = PH_IDLE;
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// Phase machine: outputs.
	always_comb begin
		tick_start = 1'b0;
		tick_done  = 1'b0;
		case (phase_q)
			PH_IDLE, PH_START: tick_start = accept && !req.mode;
			PH_DONE:           tick_done  = accept && !req.mode;
			default: begin
				tick_start = 1'b0;
				tick_done  = 1'b0;
			end
		endcase
	end

	// Scan channel advances on a start tick; history slot and pass counter only when leaving channel 0.
	always_comb begin
		scan_d  = scan_q;
		slot_d  = slot_q;
		frame_d = frame_q;
		if (tick_start) begin
			scan_d = (scan_q == CHAN_W'(NUM_CHANNELS - 1)) ? '0 : scan_q + CHAN_W'(1);
			if (scan_q == '0) begin
				frame_d = frame_q + FRAME_W'(1);
				case (slot_q)
					SLOT_W'(0): slot_d = SLOT_W'(1);
					SLOT_W'(1): slot_d = SLOT_W'(2);
					default:    slot_d = SLOT_W'(0);
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			scan_q  <= '0;
			slot_q  <= SLOT_RESET;
			frame_q <= '0;
		end else begin
			phase_q <= phase_d;
			scan_q  <= scan_d;
			slot_q  <= slot_d;
			frame_q <= frame_d;
		end
	end

	assign raddr = req.mode ? req.read_channel[CH_W-1:0] : scan_q[CH_W-1:0];

	// A read on the same edge as the write of the same row returns stale data.
	assign fwd_d = we && (waddr == raddr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_s1    <= req.mode;
			inrange_s1 <= {1'b0, req.read_channel} < (CHAN_W + 1)'(NUM_CHANNELS);
			done_s1    <= tick_done;
			start_s1   <= tick_start;
			addr_s1    <= raddr;
			slot_s1    <= (slot_q == SLOT_W'(3)) ? '0 : slot_q;
			sample_s1  <= {req.adc_result, 1'b0};
			chan_s1    <= scan_d;
			frame_s1   <= frame_d;
			fwd_s1     <= fwd_d;
			fwd_row_s1 <= wrow;
		end
	end

	asma_ram #(
		.WIDTH ($bits(row_t)),
		.DEPTH (NUM_CHANNELS)
	) u_row_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wrow),
		.re    (accept),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		if (fwd_s1) begin
			row = fwd_row_s1;
		end else if (row_vld_q[addr_s1]) begin
			row = rdata;
		end else begin
			row = '0;
		end
	end

	// Average of the three stored samples and the new doubled sample.
	assign sum = (SMP_W + 2)'(row.hist[0]) + (SMP_W + 2)'(row.hist[1])
	           + (SMP_W + 2)'(row.hist[2]) + (SMP_W + 2)'(sample_s1);

	always_comb begin
		wrow     = row;
		wrow.avg = sum[SMP_W+1:2];
		for (int i = 0; i < HIST_N; i++) begin
			if (slot_s1 == SLOT_W'(i)) begin
				wrow.hist[i] = sample_s1;
			end
		end
	end

	assign we    = s1_move && done_s1;
	assign waddr = addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (we) begin
			row_vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_move) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			rsp_q.start_conv   <= start_s1;
			rsp_q.conv_channel <= chan_s1;
			rsp_q.avg_written  <= done_s1;
			rsp_q.read_value   <= (read_s1 && inrange_s1) ? row.avg : '0;
			rsp_q.frame_count  <= frame_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The block only stalls its source when both the lookup stage and the output are full.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && rsp_valid_q && rsp_stall))
		else $error("req_stall raised with free pipeline space");

	// A start tick always moves the phase machine into convert.
	a_start_conv: assert property (@(posedge clk) disable iff (!arst_n)
		tick_start |=> (phase_q == PH_CONV))
		else $error("phase did not enter convert after a start tick");

	// The frame counter moves only on an accepted beat.
	a_frame_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(frame_q))
		else $error("frame counter changed without an accepted beat");

	// A write-back never coincides with the history read of another done tick.
	a_no_done_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> !tick_done)
		else $error("two done ticks overlap in the row read-modify-write");

endmodule

`default_nettype wire
